FILE: design/mpq_pkg.sv
// Shared types and codes for the max priority queue.
package mpq_pkg;

	localparam int ID_W    = 16;
	localparam int SCORE_W = 10;
	localparam int TAG_W   = 16;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_PEEK = 2'd1,
		OP_POP  = 2'd2,
		OP_LOAD = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_TOP   = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cell_cmd_t;

	// Slot contents handed between neighboring cells.
	typedef struct packed {
		logic   vld;
		entry_t ent;
	} slot_t;

	// True when a ranks strictly above b.
	function automatic logic beats(entry_t a, entry_t b);
		logic r;
		if (a.score != b.score) begin
			r = a.score > b.score;
		end else begin
			r = a.id < b.id;
		end
		return r;
	endfunction

endpackage

FILE: design/max_priority_queue_unit.sv
// Max priority queue: a row of sorted cells with a registered result stage.
// Result: registered, valid in the cycle after the item is accepted.
// Throughput: one item per cycle while no result is stalled; each push or pop
// settles in one pass: a broadcast compare in every cell, a one-slot shift.
// Reset: clears the valid bit of every cell, the entry count and the result
// valid flag; entry contents are not cleared and no clearing pass is needed.
module max_priority_queue_unit #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] entry_id,
	input  logic [9:0]  entry_score,
	input  logic [15:0] entry_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] top_id,
	output logic [9:0]  top_score,
	output logic [15:0] top_tag
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	mpq_pkg::opcode_t   op;
	mpq_pkg::cell_cmd_t cmd;
	mpq_pkg::slot_t     cell_slot [CAPACITY];
	mpq_pkg::slot_t     cell_nxt  [CAPACITY];
	logic               cell_gt   [CAPACITY];

	logic [CNT_W-1:0] count_q;
	logic             full, empty, acc, has_res;
	mpq_pkg::status_t res_status;

	logic             out_valid_q;
	mpq_pkg::status_t status_q;
	mpq_pkg::entry_t  top_q;

	assign op       = mpq_pkg::opcode_t'(opcode);
	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;

	assign cmd.push = acc && (op == mpq_pkg::OP_PUSH || op == mpq_pkg::OP_LOAD) && !full;
	assign cmd.pop  = acc && op == mpq_pkg::OP_POP && !empty;
	assign cmd.ent  = '{id: entry_id, score: entry_score, tag: entry_tag};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mpq_pkg::slot_t left, right;
		logic           left_gt;
		if (i == 0) begin : g_head
			assign left    = '0;
			assign left_gt = 1'b0;
		end else begin : g_body
			assign left    = cell_slot[i-1];
			assign left_gt = cell_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right = '0;
		end else begin : g_link
			assign right = cell_slot[i+1];
		end
		mpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left     (left),
			.left_gt  (left_gt),
			.right    (right),
			.slot     (cell_slot[i]),
			.gt       (cell_gt[i]),
			.slot_nxt (cell_nxt[i])
		);
	end

	always_comb begin
		has_res    = 1'b0;
		res_status = mpq_pkg::ST_TOP;
		unique case (op)
			mpq_pkg::OP_PUSH: begin
				has_res    = 1'b1;
				res_status = full ? mpq_pkg::ST_FULL : mpq_pkg::ST_TOP;
			end
			mpq_pkg::OP_PEEK: begin
				has_res    = 1'b1;
				res_status = empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_TOP;
			end
			mpq_pkg::OP_POP: begin
				has_res    = !empty;
				res_status = (count_q == CNT_W'(1)) ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_TOP;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_ready) begin
				out_valid_q <= acc && has_res;
			end
		end
	end

	// Top comes from cell 0's next value, so it already reflects this item.
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= res_status;
			top_q    <= cell_nxt[0].vld ? cell_nxt[0].ent : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_id    = top_q.id;
	assign top_score = top_q.score;
	assign top_tag   = top_q.tag;

endmodule

FILE: design/mpq_cell.sv
// One slot of the sorted queue row; cell 0 holds the top entry.
module mpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mpq_pkg::cell_cmd_t cmd,
	input  mpq_pkg::slot_t     left,
	input  logic               left_gt,
	input  mpq_pkg::slot_t     right,
	output mpq_pkg::slot_t     slot,
	output logic               gt,
	output mpq_pkg::slot_t     slot_nxt
);

	logic            vld_q;
	mpq_pkg::entry_t ent_q;

	// Empty slots always yield, so gt is a monotone mask across the row.
	assign gt = !vld_q || mpq_pkg::beats(cmd.ent, ent_q);

	assign slot.vld = vld_q;
	assign slot.ent = ent_q;

	always_comb begin
		slot_nxt.vld = vld_q;
		slot_nxt.ent = ent_q;
		if (cmd.push && gt) begin
			if (left_gt) begin
				slot_nxt = left;
			end else begin
				slot_nxt.vld = 1'b1;
				slot_nxt.ent = cmd.ent;
			end
		end else if (cmd.pop) begin
			slot_nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= slot_nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= slot_nxt.ent;
	end

endmodule

FILE: design/mpq_checker.sv
// Port-level checks for the max priority queue, bound to the top level.
module mpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] top_id,
	input logic [9:0]  top_score,
	input logic [15:0] top_tag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_id)
			&& $stable(top_score) && $stable(top_tag))
		else $error("result item changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mpq_pkg::ST_EMPTY |-> top_id == '0 && top_score == '0
			&& top_tag == '0)
		else $error("empty status with nonzero top");

	a_peek_reports: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == mpq_pkg::OP_PEEK |=> out_valid
			&& status != mpq_pkg::ST_FULL)
		else $error("peek gave no proper result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == mpq_pkg::OP_LOAD |=> !out_valid)
		else $error("silent load produced a result");

endmodule

bind max_priority_queue_unit mpq_checker u_mpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.top_id    (top_id),
	.top_score (top_score),
	.top_tag   (top_tag)
);

FILE: bench/tb.sv
// Self-checking testbench for the max priority queue unit.
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH      = 64;
	localparam int STUCK_MAX  = 2000;

	typedef struct packed {
		mpq_pkg::status_t st;
		mpq_pkg::entry_t  ent;
	} top_report_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode      = mpq_pkg::OP_PEEK;
	logic [15:0] entry_id    = '0;
	logic [9:0]  entry_score = '0;
	logic [15:0] entry_tag   = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  status;
	logic [15:0] top_id;
	logic [9:0]  top_score;
	logic [15:0] top_tag;

	mpq_pkg::entry_t held_entries[$];
	top_report_t     pending_tops[$];
	int              mismatches    = 0;
	int              stuck_cycles  = 0;
	int              send_idle_pct = 0;
	int              stall_pct     = 0;

	max_priority_queue_unit #(.CAPACITY(DEPTH)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.entry_id   (entry_id),
		.entry_score(entry_score),
		.entry_tag  (entry_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.top_id     (top_id),
		.top_score  (top_score),
		.top_tag    (top_tag)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Higher score wins; equal score goes to the smaller id.
	function automatic logic outranks(mpq_pkg::entry_t a, mpq_pkg::entry_t b);
		if (a.score != b.score) begin
			return a.score > b.score;
		end
		return a.id < b.id;
	endfunction

	// Strict compare keeps the oldest of fully equal entries on top.
	function automatic int best_slot();
		int best;
		best = 0;
		for (int i = 1; i < held_entries.size(); i++) begin
			if (outranks(held_entries[i], held_entries[best])) best = i;
		end
		return best;
	endfunction

	function automatic top_report_t report_top(mpq_pkg::status_t st);
		top_report_t rep;
		if (held_entries.size() == 0) begin
			rep.st  = mpq_pkg::ST_EMPTY;
			rep.ent = '0;
		end else begin
			rep.st  = st;
			rep.ent = held_entries[best_slot()];
		end
		return rep;
	endfunction

	function automatic void apply_queue_op(mpq_pkg::opcode_t op, mpq_pkg::entry_t ent);
		case (op)
			mpq_pkg::OP_PUSH: begin
				if (held_entries.size() < DEPTH) begin
					held_entries.push_back(ent);
					pending_tops.push_back(report_top(mpq_pkg::ST_TOP));
				end else begin
					pending_tops.push_back(report_top(mpq_pkg::ST_FULL));
				end
			end
			mpq_pkg::OP_PEEK: pending_tops.push_back(report_top(mpq_pkg::ST_TOP));
			mpq_pkg::OP_POP: begin
				if (held_entries.size() != 0) begin
					held_entries.delete(best_slot());
					pending_tops.push_back(report_top(mpq_pkg::ST_TOP));
				end
			end
			default: begin
				if (held_entries.size() < DEPTH) held_entries.push_back(ent);
			end
		endcase
	endfunction

	function automatic void check_top();
		top_report_t exp_top;
		if (pending_tops.size() == 0) begin
			$error("unexpected result: status %0d top_id %h", status, top_id);
			mismatches++;
			return;
		end
		exp_top = pending_tops.pop_front();
		if (status !== exp_top.st) begin
			$error("status: expected %0d, got %0d", exp_top.st, status);
			mismatches++;
		end
		if (top_id !== exp_top.ent.id) begin
			$error("top_id: expected %h, got %h", exp_top.ent.id, top_id);
			mismatches++;
		end
		if (top_score !== exp_top.ent.score) begin
			$error("top_score: expected %0d, got %0d", exp_top.ent.score, top_score);
			mismatches++;
		end
		if (top_tag !== exp_top.ent.tag) begin
			$error("top_tag: expected %h, got %h", exp_top.ent.tag, top_tag);
			mismatches++;
		end
	endfunction

	// Results are checked before the same-edge item is predicted.
	always @(posedge clk) begin
		if (out_valid && out_ready) check_top();
		if (in_valid && in_ready) begin
			apply_queue_op(mpq_pkg::opcode_t'(opcode),
				'{id: entry_id, score: entry_score, tag: entry_tag});
		end
		if ((out_valid && out_ready) || (in_valid && in_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : watchdog
		while (stuck_cycles < STUCK_MAX) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_item(input mpq_pkg::opcode_t op, input logic [15:0] id,
		input logic [9:0] score, input logic [15:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		entry_id    <= id;
		entry_score <= score;
		entry_tag   <= tag;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tops.size() != 0);
	endtask

	task automatic send_random_item(input int push_bias);
		mpq_pkg::opcode_t op;
		logic [15:0]      id;
		logic [9:0]       score;
		if ($urandom_range(99) < push_bias) begin
			op = ($urandom_range(3) == 0) ? mpq_pkg::OP_LOAD : mpq_pkg::OP_PUSH;
		end else begin
			op = ($urandom_range(4) == 0) ? mpq_pkg::OP_PEEK : mpq_pkg::OP_POP;
		end
		// narrow keys half the time so score and id ties are common
		if ($urandom_range(1) == 0) begin
			id    = 16'($urandom_range(3));
			score = $urandom_range(1) ? 10'(1020 + $urandom_range(3)) : 10'($urandom_range(3));
		end else begin
			id    = 16'($urandom);
			score = 10'($urandom);
		end
		send_item(op, id, score, 16'($urandom));
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_item(mpq_pkg::OP_PEEK, 16'hFFFF, 10'h3FF, 16'hFFFF);
		send_item(mpq_pkg::OP_POP,  16'hFFFF, 10'h3FF, 16'hFFFF);
		send_item(mpq_pkg::OP_PUSH, 16'h1234, 10'd5,   16'hAAAA);
		send_item(mpq_pkg::OP_PUSH, 16'hFFFF, 10'h3FF, 16'hFFFF);
		send_item(mpq_pkg::OP_PUSH, 16'h0000, 10'h3FF, 16'h0000);
		// same score and id as the top: the older one must stay on top
		send_item(mpq_pkg::OP_LOAD, 16'h0000, 10'h3FF, 16'h5555);
		send_item(mpq_pkg::OP_PEEK, 16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_PUSH, 16'hFFFF, 10'h000, 16'h0001);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_PEEK, 16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_POP,  16'h0000, 10'h000, 16'h0000);
		send_item(mpq_pkg::OP_PEEK, 16'h0000, 10'h000, 16'h0000);
	endtask

	task automatic test_full_queue();
		send_idle_pct = 0;
		stall_pct     = 0;
		for (int i = 0; i < DEPTH; i++) begin
			send_item(mpq_pkg::OP_LOAD, 16'($urandom), 10'($urandom), 16'($urandom));
		end
		send_item(mpq_pkg::OP_PUSH, 16'h0000, 10'h3FF, 16'hBEEF);
		send_item(mpq_pkg::OP_LOAD, 16'h0000, 10'h3FF, 16'hCAFE);
		send_item(mpq_pkg::OP_PEEK, 16'h0000, 10'h000, 16'h0000);
		for (int i = 0; i < DEPTH; i++) begin
			send_item(mpq_pkg::OP_POP, 16'($urandom), 10'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_random_mix(input int idle_pct, input int stall, input int n_items);
		int push_bias;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		push_bias     = 50;
		for (int i = 0; i < n_items; i++) begin
			// switch to a random fill or drain trend every 40 items to visit both empty and full
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0:       push_bias = 20;
					1:       push_bias = 50;
					default: push_bias = 85;
				endcase
			end
			if (i == n_items / 2) wait_drained();
			send_random_item(push_bias);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_queue();
		test_random_mix(0, 0, 290);
		test_random_mix(62, 0, 290);
		test_random_mix(0, 62, 290);
		test_random_mix(9, 9, 290);
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
